### rtl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg
// shared types and constants of the run-length tga pixel decoder
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned PIXCNT_W  = 2 * DIM_W;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // packet header split point and run bias
  localparam logic [BYTE_W-1:0] RUN_FLAG_MIN = 8'd128;
  localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;

  // last byte slot of a pixel: 24-bit and 32-bit pixels
  localparam logic [SLOT_W-1:0] LAST_SLOT_RGB  = 2'd2;
  localparam logic [SLOT_W-1:0] LAST_SLOT_RGBA = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_ALPHA_PRESENT = 2'd2
  } cfg_reg_t;

  // configuration as seen by the decode core
  typedef struct packed {
    logic                alpha_present;
    logic [PIXCNT_W-1:0] total_pixels;
  } cfg_t;

endpackage

### rtl/tga_rle_in_if.sv
// ----------------------------------------------------------------------------
// tga_rle_in_if
// byte stream channel into the decoder
// ----------------------------------------------------------------------------
interface tga_rle_in_if;
  import tga_rle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

### rtl/tga_rle_out_if.sv
// ----------------------------------------------------------------------------
// tga_rle_out_if
// pixel result channel out of the decoder
// ----------------------------------------------------------------------------
interface tga_rle_out_if;
  import tga_rle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic [BYTE_W-1:0] repeat_res;
  logic              image_done;
  logic              overrun_error;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output image_done, output overrun_error,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input image_done, input overrun_error,
                  output ready);
endinterface

### rtl/tga_rle_cfg_if.sv
// ----------------------------------------------------------------------------
// tga_rle_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface tga_rle_cfg_if;
  import tga_rle_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tga_rle_cfg_regs.sv
// ----------------------------------------------------------------------------
// tga_rle_cfg_regs
// configuration registers and the registered pixel count of the image
// ----------------------------------------------------------------------------
module tga_rle_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  tga_rle_cfg_if.sink        cfg_chan,
  output tga_rle_pkg::cfg_t  cfg
);
  import tga_rle_pkg::*;

  logic [DIM_W-1:0]    width_r,  width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic                alpha_r,  alpha_nxt;
  logic [PIXCNT_W-1:0] total_r,  total_nxt;
  logic                wr;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid;

  // product is taken with the value being written so it is never stale
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    alpha_nxt  = alpha_r;
    if (wr) begin
      case (cfg_chan.index)
        REG_IMAGE_WIDTH:   width_nxt  = cfg_chan.data;
        REG_IMAGE_HEIGHT:  height_nxt = cfg_chan.data;
        REG_ALPHA_PRESENT: alpha_nxt  = cfg_chan.data[0];
        default: ;
      endcase
    end
    total_nxt = PIXCNT_W'(width_nxt) * PIXCNT_W'(height_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      alpha_r  <= 1'b0;
      total_r  <= PIXCNT_W'(1);
    end else if (wr) begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      alpha_r  <= alpha_nxt;
      total_r  <= total_nxt;
    end
  end

  assign cfg.alpha_present = alpha_r;
  assign cfg.total_pixels  = total_r;
endmodule

### rtl/tga_rle_core.sv
// ----------------------------------------------------------------------------
// tga_rle_core
// input register, packet and pixel decode, result register
// ----------------------------------------------------------------------------
module tga_rle_core (
  input  logic              clk,
  input  logic              rst_n,
  input  tga_rle_pkg::cfg_t cfg,
  tga_rle_in_if.sink        in_chan,
  tga_rle_out_if.source     out_chan
);
  import tga_rle_pkg::*;

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_start_r;

  // decode state
  logic                expect_hdr_r,  expect_hdr_nxt;
  logic                run_mode_r,    run_mode_nxt;
  logic [BYTE_W-1:0]   raw_left_r,    raw_left_nxt;
  logic [SLOT_W-1:0]   byte_slot_r,   byte_slot_nxt;
  logic [31:0]         pix_bytes_r,   pix_bytes_nxt;
  logic [PIXCNT_W-1:0] emitted_r,     emitted_nxt;
  logic                stopped_r,     stopped_nxt;

  // result register
  logic              out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0] red_r, green_r, blue_r, alpha_r, rep_r;
  logic              done_r, ovr_r;
  logic [BYTE_W-1:0] rep_nxt;
  logic              done_nxt, ovr_nxt, produce;

  logic              adv;
  logic              eh, st;
  logic [PIXCNT_W-1:0] em;
  logic [SLOT_W-1:0] slot, last_slot;
  logic [BYTE_W-1:0] count;
  logic [PIXCNT_W:0] need;
  logic [31:0]       pb;

  assign adv            = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r  <= in_chan.data_byte;
      in_start_r <= in_chan.start_of_image;
    end
  end

  always_comb begin
    // start flag restarts decoding before the byte is looked at
    eh   = in_start_r ? 1'b1 : expect_hdr_r;
    st   = in_start_r ? 1'b0 : stopped_r;
    em   = in_start_r ? '0   : emitted_r;
    slot = in_start_r ? '0   : byte_slot_r;

    expect_hdr_nxt = eh;
    run_mode_nxt   = run_mode_r;
    raw_left_nxt   = raw_left_r;
    byte_slot_nxt  = slot;
    pix_bytes_nxt  = pix_bytes_r;
    emitted_nxt    = em;
    stopped_nxt    = st;

    produce  = 1'b0;
    rep_nxt  = '0;
    done_nxt = 1'b0;
    ovr_nxt  = 1'b0;

    last_slot = cfg.alpha_present ? LAST_SLOT_RGBA : LAST_SLOT_RGB;
    count     = (in_byte_r < RUN_FLAG_MIN) ? in_byte_r + 8'd1 : in_byte_r - RUN_BIAS;
    need      = {1'b0, em} + (PIXCNT_W+1)'(count);
    pb        = (slot == '0) ? 32'd0 : pix_bytes_r;

    if (st) begin
      // ignore bytes until the next start flag
    end else if (eh) begin
      run_mode_nxt = (in_byte_r >= RUN_FLAG_MIN);
      if (need > {1'b0, cfg.total_pixels}) begin
        produce     = 1'b1;
        ovr_nxt     = 1'b1;
        stopped_nxt = 1'b1;
      end else begin
        raw_left_nxt   = count;
        byte_slot_nxt  = '0;
        pix_bytes_nxt  = '0;
        expect_hdr_nxt = 1'b0;
      end
    end else begin
      case (slot)
        2'd0:    pb[7:0]   = in_byte_r;
        2'd1:    pb[15:8]  = in_byte_r;
        2'd2:    pb[23:16] = in_byte_r;
        default: pb[31:24] = in_byte_r;
      endcase
      pix_bytes_nxt = pb;
      if (slot < last_slot) begin
        byte_slot_nxt = slot + 2'd1;
      end else begin
        byte_slot_nxt = '0;
        if (run_mode_r) begin
          rep_nxt      = raw_left_r;
          raw_left_nxt = '0;
        end else begin
          rep_nxt      = 8'd1;
          raw_left_nxt = raw_left_r - 8'd1;
        end
        emitted_nxt = em + PIXCNT_W'(rep_nxt);
        if (raw_left_nxt == '0) expect_hdr_nxt = 1'b1;
        done_nxt = (emitted_nxt == cfg.total_pixels);
        if (done_nxt) stopped_nxt = 1'b1;
        produce = 1'b1;
      end
    end

    out_vld_nxt = adv ? produce : (out_vld_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      run_mode_r   <= 1'b0;
      raw_left_r   <= '0;
      byte_slot_r  <= '0;
      pix_bytes_r  <= '0;
      emitted_r    <= '0;
      stopped_r    <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        expect_hdr_r <= expect_hdr_nxt;
        run_mode_r   <= run_mode_nxt;
        raw_left_r   <= raw_left_nxt;
        byte_slot_r  <= byte_slot_nxt;
        pix_bytes_r  <= pix_bytes_nxt;
        emitted_r    <= emitted_nxt;
        stopped_r    <= stopped_nxt;
      end
    end
  end

  // result payload, zero on an overrun
  always_ff @(posedge clk) begin
    if (adv && produce) begin
      red_r   <= ovr_nxt ? '0 : pb[23:16];
      green_r <= ovr_nxt ? '0 : pb[15:8];
      blue_r  <= ovr_nxt ? '0 : pb[7:0];
      alpha_r <= (ovr_nxt || !cfg.alpha_present) ? '0 : pb[31:24];
      rep_r   <= rep_nxt;
      done_r  <= done_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.red           = red_r;
  assign out_chan.green         = green_r;
  assign out_chan.blue          = blue_r;
  assign out_chan.alpha         = alpha_r;
  assign out_chan.repeat_res    = rep_r;
  assign out_chan.image_done    = done_r;
  assign out_chan.overrun_error = ovr_r;
endmodule

### rtl/tga_rle_pixel_decoder.sv
// a byte that ends a pixel or an overrun header passes the input register and then the
//   result register, which it enters once that register is free or its result transfers
// throughput: one byte per cycle unless a waiting result stalls the input, set by the state update of the decode core
// while a result waits in the output register one more byte is taken into the input
//   register, then the input stalls until that result transfers
// reset: synchronous active-low rst_n; width and height 1, no alpha, waiting for a header
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length tga (type 10) pixel data decoder, one byte in, one pixel run out
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic          clk,
  input  logic          rst_n,
  tga_rle_cfg_if.sink   cfg_chan,
  tga_rle_in_if.sink    in_chan,
  tga_rle_out_if.source out_chan
);
  import tga_rle_pkg::*;

  // alpha flag and width*height, the product is refreshed on every register write
  cfg_t cfg;

  tga_rle_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // packet header parse, byte gathering in b,g,r(,a) order, run counting,
  // overrun check before any pixel of a packet is emitted
  tga_rle_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );
endmodule

### rtl/tga_rle_checker.sv
// ----------------------------------------------------------------------------
// tga_rle_checker
// port-level checks on the decoder result channel
// ----------------------------------------------------------------------------
module tga_rle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_repeat_res,
  input logic       out_image_done,
  input logic       out_overrun_error
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_repeat_res) && $stable(out_red))
    else $error("stalled result changed");

  // an overrun result carries no pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overrun_error |-> out_repeat_res == 8'd0 && !out_image_done
      && out_red == 8'd0)
    else $error("overrun result carries pixel data");

  // a pixel result covers one to 128 pixels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overrun_error |-> out_repeat_res != 8'd0 && out_repeat_res <= 8'd128)
    else $error("repeat count out of range");

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_red           (out_chan.red),
  .out_repeat_res    (out_chan.repeat_res),
  .out_image_done    (out_chan.image_done),
  .out_overrun_error (out_chan.overrun_error)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the run-length tga pixel decoder: a byte driver with
// bursts and gaps, a stalling pixel monitor, and a bit-exact decode predictor
// ----------------------------------------------------------------------------
module tb_top;
  import tga_rle_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1750;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_image;
  } stream_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] repeat_res;
    logic              image_done;
    logic              overrun_error;
  } pixel_res_t;

  // receiver behaviour, switched at random by the monitor
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_t;

  logic clk;
  logic rst_n;

  tga_rle_cfg_if cfg_bus ();
  tga_rle_in_if  in_bus ();
  tga_rle_out_if out_bus ();

  tga_rle_pixel_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // bytes waiting to be driven, pixels waiting to be seen
  stream_item_t byte_q[$];
  pixel_res_t   pixel_q[$];
  int unsigned  fail_count;
  int unsigned  stim_items;

  // register copy used by the predictor
  logic [DIM_W-1:0] reg_width;
  logic [DIM_W-1:0] reg_height;
  logic             reg_alpha;

  // decoder state copy
  logic                dec_expect_hdr;
  logic                dec_run;
  logic [BYTE_W-1:0]   dec_left;
  logic [SLOT_W-1:0]   dec_slot;
  logic [31:0]         dec_pix;
  logic [PIXCNT_W-1:0] dec_emitted;
  logic                dec_stopped;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_decoder();
    reg_width      = 16'd1;
    reg_height     = 16'd1;
    reg_alpha      = 1'b0;
    dec_expect_hdr = 1'b1;
    dec_run        = 1'b0;
    dec_left       = '0;
    dec_slot       = '0;
    dec_pix        = '0;
    dec_emitted    = '0;
    dec_stopped    = 1'b0;
  endfunction

  // returns 1 when the byte produces a pixel (or overrun) result
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic sof,
                                     output pixel_res_t r);
    logic [PIXCNT_W-1:0] total;
    logic [PIXCNT_W:0]   reach;
    logic [BYTE_W-1:0]   count;
    logic [BYTE_W-1:0]   rep;
    logic [SLOT_W-1:0]   last;
    logic                done;
    r     = '0;
    total = PIXCNT_W'(reg_width) * PIXCNT_W'(reg_height);
    // start flag restarts before the byte is looked at
    if (sof) begin
      dec_emitted    = '0;
      dec_stopped    = 1'b0;
      dec_slot       = '0;
      dec_expect_hdr = 1'b1;
    end
    if (dec_stopped) return 1'b0;

    if (dec_expect_hdr) begin
      if (b < RUN_FLAG_MIN) begin
        count   = b + 8'd1;
        dec_run = 1'b0;
      end else begin
        count   = b - RUN_BIAS;
        dec_run = 1'b1;
      end
      reach = (PIXCNT_W+1)'(dec_emitted) + (PIXCNT_W+1)'(count);
      if (reach > (PIXCNT_W+1)'(total)) begin
        r.overrun_error = 1'b1;
        dec_stopped     = 1'b1;
        return 1'b1;
      end
      dec_left       = count;
      dec_slot       = '0;
      dec_pix        = '0;
      dec_expect_hdr = 1'b0;
      return 1'b0;
    end

    last = reg_alpha ? LAST_SLOT_RGBA : LAST_SLOT_RGB;
    if (dec_slot == '0) dec_pix = '0;
    dec_pix[8*dec_slot +: 8] = b;
    if (dec_slot < last) begin
      dec_slot = dec_slot + 2'd1;
      return 1'b0;
    end
    dec_slot = '0;

    if (dec_run) begin
      rep      = dec_left;
      dec_left = '0;
    end else begin
      rep      = 8'd1;
      dec_left = dec_left - 8'd1;
    end
    dec_emitted = dec_emitted + PIXCNT_W'(rep);
    if (dec_left == '0) dec_expect_hdr = 1'b1;
    done = (dec_emitted == total);
    if (done) dec_stopped = 1'b1;

    r.red        = dec_pix[23:16];
    r.green      = dec_pix[15:8];
    r.blue       = dec_pix[7:0];
    r.alpha      = reg_alpha ? dec_pix[31:24] : 8'd0;
    r.repeat_res = rep;
    r.image_done = done;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // far above the slowest legal run: every result stalled, every byte gapped
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // byte driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned  burst_left;
  int unsigned  gap_left;
  stream_item_t drv_item;
  pixel_res_t   drv_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid          <= 1'b0;
      in_bus.data_byte      <= '0;
      in_bus.start_of_image <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // predict on every accepted transfer
      if (in_bus.valid && in_bus.ready) begin
        if (decode_byte(in_bus.data_byte, in_bus.start_of_image, drv_res))
          pixel_q.push_back(drv_res);
      end
      // the bus slot is free once the current byte has gone (or nothing is up)
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0 || byte_q.size() == 0) begin
          in_bus.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          drv_item = byte_q.pop_front();
          in_bus.valid          <= 1'b1;
          in_bus.data_byte      <= drv_item.data_byte;
          in_bus.start_of_image <= drv_item.start_of_image;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // next burst; half of the gaps are empty so long runs go back to back
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(12, 1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pixel monitor with its own stall pattern
  // ---------------------------------------------------------------------------
  ready_mode_t rdy_mode;
  int unsigned rdy_left;
  pixel_res_t  mon_exp;

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rdy_mode = RDY_ALWAYS;
      rdy_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel result transfer with nothing expected");
          fail_count++;
        end else begin
          mon_exp = pixel_q.pop_front();
          check_field("red", mon_exp.red, out_bus.red);
          check_field("green", mon_exp.green, out_bus.green);
          check_field("blue", mon_exp.blue, out_bus.blue);
          check_field("alpha", mon_exp.alpha, out_bus.alpha);
          check_field("repeat_res", mon_exp.repeat_res, out_bus.repeat_res);
          check_field("image_done", 8'(mon_exp.image_done), 8'(out_bus.image_done));
          check_field("overrun_error", 8'(mon_exp.overrun_error),
                      8'(out_bus.overrun_error));
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = ready_mode_t'($urandom_range(3, 0));
        rdy_left = $urandom_range(60, 10);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_bus.ready <= 1'b1;
        RDY_COIN:   out_bus.ready <= 1'($urandom_range(1, 0));
        RDY_SPARSE: out_bus.ready <= ($urandom_range(5, 0) == 0);
        default:    out_bus.ready <= ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic sof, input bit counted);
    stream_item_t it;
    it.data_byte      = b;
    it.start_of_image = sof;
    byte_q.push_back(it);
    if (counted) stim_items++;
  endtask

  // one register write over the config channel, mirrored into the predictor
  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   reg_width  = val;
      REG_IMAGE_HEIGHT:  reg_height = val;
      REG_ALPHA_PRESENT: reg_alpha  = val[0];
      default: ;
    endcase
  endtask

  // all bytes sent, all pixels seen, then a drain wait for header-only bytes;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_bus.valid || pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a well-formed image with random content, sometimes cut short or overrun
  task automatic gen_image(input longint unsigned px_total, input int unsigned bpp);
    longint unsigned remaining;
    int unsigned     max_cnt, cnt, n_bytes, cut, pkt_cap, packets, k;
    bit              first, is_run, trunc;
    remaining = px_total;
    first     = 1'b1;
    packets   = 0;
    // huge images are never finished, only a few packets of them
    pkt_cap   = (px_total > 2000) ? 5 : 1000;
    if (px_total == 0) begin
      push_byte(8'($urandom_range(255, 0)), 1'b1, 1'b1);
      return;
    end
    while (remaining != 0 && packets < pkt_cap) begin
      max_cnt = (remaining > 128) ? 128 : int'(remaining);
      is_run  = 1'($urandom_range(1, 0));
      // packet larger than what is left of the image
      if (remaining < 128 && $urandom_range(15, 0) == 0) begin
        cnt = $urandom_range(128, max_cnt + 1);
        push_byte(is_run ? 8'(cnt + 127) : 8'(cnt - 1), first, 1'b1);
        return;
      end
      if (is_run)
        cnt = ($urandom_range(3, 0) == 0) ? max_cnt : $urandom_range(max_cnt, 1);
      else if ($urandom_range(9, 0) == 0)
        cnt = $urandom_range(max_cnt, 1);
      else
        cnt = $urandom_range((max_cnt < 6) ? max_cnt : 6, 1);
      push_byte(is_run ? 8'(cnt + 127) : 8'(cnt - 1), first, 1'b1);
      first   = 1'b0;
      n_bytes = (is_run ? 1 : cnt) * bpp;
      trunc   = ($urandom_range(39, 0) == 0);
      cut     = $urandom_range(n_bytes - 1, 0);
      for (k = 0; k < n_bytes; k++) begin
        if (trunc && k == cut) return;
        push_byte(8'($urandom_range(255, 0)), 1'b0, 1'b1);
      end
      remaining -= cnt;
      packets++;
    end
    // trailing bytes after completion are dropped by the block
    if (remaining == 0)
      repeat ($urandom_range(2, 0)) push_byte(8'($urandom_range(255, 0)), 1'b0, 1'b0);
  endtask

  task automatic gen_noise(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(255, 0)), ($urandom_range(5, 0) == 0), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [DIM_W-1:0] w, h;
    logic             a;
    int unsigned      target, pick;

    in_bus.valid          = 1'b0;
    in_bus.data_byte      = '0;
    in_bus.start_of_image = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_IMAGE_WIDTH;
    cfg_bus.data          = '0;
    out_bus.ready         = 1'b0;
    rst_n                 = 1'b0;
    fail_count            = 0;
    stim_items            = 0;
    reset_decoder();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: 1x1 image, 24-bit pixels
    push_byte(8'h00, 1'b1, 1'b0);          // raw packet of one pixel
    push_byte(8'h00, 1'b0, 1'b0);          // b
    push_byte(8'hFF, 1'b0, 1'b0);          // g
    push_byte(8'h80, 1'b0, 1'b0);          // r, completes the image
    push_byte(8'h5A, 1'b0, 1'b0);          // ignored after completion
    push_byte(8'h81, 1'b1, 1'b0);          // restart, run of two: overrun
    push_byte(8'hA5, 1'b0, 1'b0);          // ignored while stopped
    wait_idle();

    // largest image, 32-bit pixels
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_ALPHA_PRESENT, 16'd1);
    push_byte(8'hFF, 1'b1, 1'b0);          // longest run
    push_byte(8'h11, 1'b0, 1'b0);
    push_byte(8'h22, 1'b0, 1'b0);
    push_byte(8'h33, 1'b0, 1'b0);
    push_byte(8'h44, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);          // longest raw packet
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);          // three bytes of the next pixel
    push_byte(8'h02, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0);
    wait_idle();

    // alpha dropped with the pixel sitting on its fourth slot
    write_reg(REG_ALPHA_PRESENT, 16'd0);
    push_byte(8'hC3, 1'b0, 1'b0);
    wait_idle();

    // zero-size image: first header overruns
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    push_byte(8'h00, 1'b1, 1'b0);
    wait_idle();

    // random phases, each with its own register setting
    while (stim_items < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(11, 0);
      case (pick)
        0:       begin w = 16'hFFFF; h = 16'hFFFF; end
        1:       begin w = 16'hFFFF; h = 16'd1; end
        2:       begin w = 16'd1; h = 16'hFFFF; end
        3:       begin w = 16'd1; h = 16'd1; end
        4:       begin w = 16'($urandom_range(1, 0) * $urandom_range(9, 1));
                       h = (w == 0) ? 16'($urandom_range(9, 1)) : 16'd0; end
        5:       begin w = 16'($urandom_range(400, 100)); h = 16'($urandom_range(2, 1)); end
        default: begin w = 16'($urandom_range(16, 1)); h = 16'($urandom_range(12, 1)); end
      endcase
      a = 1'($urandom_range(1, 0));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_ALPHA_PRESENT, 16'(a));
      target = stim_items + $urandom_range(200, 80);
      while (stim_items < target) begin
        if ($urandom_range(9, 0) < 8)
          gen_image(longint'(w) * longint'(h), a ? 4 : 3);
        else
          gen_noise($urandom_range(12, 1));
      end
    end

    wait_idle();
    if (pixel_q.size() != 0) begin
      $error("%0d expected pixel results never arrived", pixel_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
